/* rtl/sbb_pkg.sv */
// Shared types and constants of the separable box blur core.
// No dependencies; every other file imports this package.
`default_nettype none
package sbb_pkg;

    localparam int PIXEL_W    = 32;
    localparam int LANES      = 4;
    localparam int LANE_W     = 8;
    localparam int RADIUS_W   = 4;
    localparam int DIM_W      = 7;
    localparam int COUNT_W    = RADIUS_W + 1;
    localparam int SUM_W      = 13;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_RADIUS = 15;

    localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [RADIUS_W-1:0] RESET_RADIUS = 4'd1;
    localparam logic [DIM_W-1:0]    RESET_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]    RESET_HEIGHT = 7'd64;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [RADIUS_W-1:0] r;
    } geom_t;

    typedef struct packed {
        logic             start;
        logic             vert;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
    } win_req_t;

endpackage
`default_nettype wire

/* rtl/sbb_frame_ram.sv */
// Frame store: one write port, one registered read port.
// Depends on sbb_pkg for the pixel width.
`default_nettype none
module sbb_frame_ram
    import sbb_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW    = 12
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [PIXEL_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [AW-1:0]      raddr,
    output logic      [PIXEL_W-1:0] rdata
);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/sbb_div4.sv */
// Four-lane restoring divider, one quotient bit per cycle in every lane.
// Depends on sbb_pkg for sum, count and channel widths.
`default_nettype none
module sbb_div4
    import sbb_pkg::*;
(
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [LANES-1:0][SUM_W-1:0]    dividend,
    input  wire logic [COUNT_W-1:0]             divisor,
    output logic                                done,
    output logic      [LANES-1:0][LANE_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [COUNT_W-1:0]            div_reg;
    logic [LANES-1:0][SUM_W-1:0]   q_reg;
    logic [LANES-1:0][COUNT_W-1:0] rem_reg;
    logic [LANES-1:0][SUM_W-1:0]   q_next;
    logic [LANES-1:0][COUNT_W-1:0] rem_next;
    logic [LANES-1:0][COUNT_W:0]   trial;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            trial[i] = {rem_reg[i], q_reg[i][SUM_W-1]};
            if (trial[i] >= {1'b0, div_reg}) begin
                rem_next[i] = COUNT_W'(trial[i] - {1'b0, div_reg});
                q_next[i]   = {q_reg[i][SUM_W-2:0], 1'b1};
            end else begin
                rem_next[i] = trial[i][COUNT_W-1:0];
                q_next[i]   = {q_reg[i][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                div_reg  <= divisor;
                q_reg    <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            quotient[i] = q_reg[i][LANE_W-1:0];
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

/* rtl/sbb_window.sv */
// Window engine: walks the 2r+1 taps of one window through a frame store,
// sums the channels and divides by the tap count. Depends on sbb_pkg, sbb_div4.
`default_nettype none
module sbb_window
    import sbb_pkg::*;
#(
    parameter int AW = 12
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire geom_t              geom,
    input  wire win_req_t           req,
    output logic                    rd_en,
    output logic      [AW-1:0]      rd_addr,
    input  wire logic [PIXEL_W-1:0] rd_data,
    output logic                    done,
    output logic      [PIXEL_W-1:0] result
);

    typedef enum logic [2:0] {W_IDLE, W_FETCH, W_DRAIN, W_DIVGO, W_DIVWAIT} wstate_t;

    wstate_t                     state_reg;
    logic                        vert_reg;
    logic [DIM_W-1:0]            centre_reg;
    logic [DIM_W-1:0]            other_reg;
    logic [DIM_W-1:0]            hi_reg;
    logic [PROD_W-1:0]           base_reg;
    logic [COUNT_W-1:0]          t_reg;
    logic                        acc_valid_reg;
    logic [LANES-1:0][SUM_W-1:0] sum_reg;
    logic [PIXEL_W-1:0]          result_reg;
    logic                        done_reg;

    logic signed [DIM_W+1:0]     coord_s;
    logic [DIM_W-1:0]            coord;
    logic [PROD_W-1:0]           addr_full;
    logic [COUNT_W-1:0]          last_tap;
    logic                        div_start;
    logic                        div_done;
    logic [LANES-1:0][LANE_W-1:0] div_q;

    assign last_tap = {geom.r, 1'b0};

    // Tap coordinate, clamped to the frame edge.
    always_comb begin
        coord_s = $signed({2'b00, centre_reg}) - $signed({5'b00000, geom.r})
                + $signed({4'b0000, t_reg});
        if (coord_s[DIM_W+1]) begin
            coord = '0;
        end else if (coord_s[DIM_W:0] > {1'b0, hi_reg}) begin
            coord = hi_reg;
        end else begin
            coord = coord_s[DIM_W-1:0];
        end
        if (vert_reg) begin
            addr_full = PROD_W'(coord) * PROD_W'(geom.w) + PROD_W'(other_reg);
        end else begin
            addr_full = base_reg + PROD_W'(coord);
        end
    end

    assign rd_en   = (state_reg == W_FETCH);
    assign rd_addr = AW'(addr_full);
    assign div_start = (state_reg == W_DIVGO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= W_IDLE;
            acc_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            done_reg      <= 1'b0;
            acc_valid_reg <= (state_reg == W_FETCH);
            if (acc_valid_reg) begin
                for (int i = 0; i < LANES; i++) begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(rd_data[LANE_W*i +: LANE_W]);
                end
            end
            case (state_reg)
                W_IDLE: begin
                    if (req.start) begin
                        vert_reg   <= req.vert;
                        centre_reg <= req.vert ? req.y : req.x;
                        other_reg  <= req.x;
                        hi_reg     <= req.vert ? geom.h - DIM_W'(1) : geom.w - DIM_W'(1);
                        base_reg   <= PROD_W'(req.y) * PROD_W'(geom.w);
                        t_reg      <= '0;
                        sum_reg    <= '0;
                        state_reg  <= W_FETCH;
                    end
                end
                W_FETCH: begin
                    if (t_reg == last_tap) begin
                        state_reg <= W_DRAIN;
                    end else begin
                        t_reg <= t_reg + COUNT_W'(1);
                    end
                end
                W_DRAIN: begin
                    state_reg <= W_DIVGO;
                end
                W_DIVGO: begin
                    state_reg <= W_DIVWAIT;
                end
                W_DIVWAIT: begin
                    if (div_done) begin
                        result_reg <= div_q;
                        done_reg   <= 1'b1;
                        state_reg  <= W_IDLE;
                    end
                end
                default: begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    sbb_div4 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  ({geom.r, 1'b1}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* rtl/separable_box_blur_core.sv */
// Top level of the separable box blur core: control, configuration and two frame stores.
// Depends on sbb_pkg, sbb_frame_ram and sbb_window.
//
//   Channel   Signals                                      Direction
//   s_        s_valid s_ready s_command s_pixel_in         in  (load or emit command)
//   m_        m_valid m_ready m_pixel_out m_frame_end      out (one item per emit)
//   cfg_      cfg_valid cfg_ready cfg_index cfg_data       in  (register writes)
//
// From the acceptance of an emit item to m_valid, the window engine reads 2r+1 taps
// through one memory read port, one per cycle, then divides, with handoff states around
// both steps, and the result waits in ST_EOUT while the output register is still full.
// The first emit after reset, a stored load or a register write first runs the horizontal pass.
// Reset is synchronous and active low; the frame stores are not cleared.
// A finished pixel waits in the output register while loads are still accepted.
`default_nettype none
module separable_box_blur_core
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [PIXEL_W-1:0]    s_pixel_in,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [PIXEL_W-1:0]    m_pixel_out,
    output logic                       m_frame_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_HRUN, ST_ESTART, ST_ERUN, ST_EOUT} state_t;

    state_t              state_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [PW-1:0]       load_pos_reg;
    logic [PW-1:0]       emit_pos_reg;
    logic [DIM_W-1:0]    ex_reg;
    logic [DIM_W-1:0]    ey_reg;
    logic [PW-1:0]       h_pos_reg;
    logic [DIM_W-1:0]    hx_reg;
    logic [DIM_W-1:0]    hy_reg;
    logic                rows_done_reg;
    logic                vert_reg;
    win_req_t            req_reg;
    logic                m_valid_reg;
    logic [PIXEL_W-1:0]  m_pixel_reg;
    logic                m_frame_end_reg;

    geom_t               geom;
    logic [PROD_W-1:0]   area;
    logic [PW-1:0]       total;
    logic [PW-1:0]       last_pos;
    logic [DIM_W-1:0]    hx_next;
    logic [DIM_W-1:0]    hy_next;
    logic [DIM_W-1:0]    ex_next;
    logic [DIM_W-1:0]    ey_next;
    logic                s_take;
    logic                src_we;
    logic                row_we;
    logic                emit_wrap;
    logic                out_free;

    logic                eng_rd_en;
    logic [AW-1:0]       eng_rd_addr;
    logic [PIXEL_W-1:0]  eng_rd_data;
    logic [PIXEL_W-1:0]  src_rdata;
    logic [PIXEL_W-1:0]  row_rdata;
    logic                eng_done;
    logic [PIXEL_W-1:0]  eng_result;

    // Effective geometry: zero sizes act as one, oversize sizes clamp to the store, the radius to MAX_RADIUS.
    always_comb begin
        if (width_reg == '0) begin
            geom.w = DIM_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            geom.w = DIM_W'(MAX_WIDTH);
        end else begin
            geom.w = width_reg;
        end
        if (height_reg == '0) begin
            geom.h = DIM_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            geom.h = DIM_W'(MAX_HEIGHT);
        end else begin
            geom.h = height_reg;
        end
        if (32'(radius_reg) > MAX_RADIUS) begin
            geom.r = RADIUS_W'(MAX_RADIUS);
        end else begin
            geom.r = radius_reg;
        end
    end

    assign area     = PROD_W'(geom.w) * PROD_W'(geom.h);
    assign total    = PW'(area);
    assign last_pos = total - PW'(1);

    // Raster stepping for the horizontal pass and for the emit position.
    always_comb begin
        if (hx_reg == geom.w - DIM_W'(1)) begin
            hx_next = '0;
            hy_next = hy_reg + DIM_W'(1);
        end else begin
            hx_next = hx_reg + DIM_W'(1);
            hy_next = hy_reg;
        end
        if (ex_reg == geom.w - DIM_W'(1)) begin
            ex_next = '0;
            ey_next = ey_reg + DIM_W'(1);
        end else begin
            ex_next = ex_reg + DIM_W'(1);
            ey_next = ey_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_take    = s_valid && s_ready;
    assign src_we    = s_take && (s_command == CMD_LOAD) && (load_pos_reg < total);
    assign row_we    = (state_reg == ST_HRUN) && eng_done;
    assign emit_wrap = (emit_pos_reg >= total);
    assign out_free  = !m_valid_reg || m_ready;
    assign eng_rd_data = vert_reg ? row_rdata : src_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            radius_reg      <= RESET_RADIUS;
            width_reg       <= RESET_WIDTH;
            height_reg      <= RESET_HEIGHT;
            load_pos_reg    <= '0;
            emit_pos_reg    <= '0;
            ex_reg          <= '0;
            ey_reg          <= '0;
            h_pos_reg       <= '0;
            hx_reg          <= '0;
            hy_reg          <= '0;
            rows_done_reg   <= 1'b0;
            vert_reg        <= 1'b0;
            req_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            req_reg.start <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Any write to a defined register restarts the frame.
            if (cfg_valid && (cfg_index == REG_BLUR_RADIUS || cfg_index == REG_FRAME_WIDTH
                              || cfg_index == REG_FRAME_HEIGHT)) begin
                case (cfg_index)
                    REG_BLUR_RADIUS:  radius_reg <= cfg_data[RADIUS_W-1:0];
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: begin
                    end
                endcase
                load_pos_reg  <= '0;
                emit_pos_reg  <= '0;
                ex_reg        <= '0;
                ey_reg        <= '0;
                rows_done_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_take) begin
                        if (s_command == CMD_LOAD) begin
                            if (src_we) begin
                                load_pos_reg  <= load_pos_reg + PW'(1);
                                rows_done_reg <= 1'b0;
                            end
                        end else if (!rows_done_reg) begin
                            h_pos_reg <= '0;
                            hx_reg    <= '0;
                            hy_reg    <= '0;
                            vert_reg  <= 1'b0;
                            req_reg   <= '{start: 1'b1, vert: 1'b0, x: '0, y: '0};
                            state_reg <= ST_HRUN;
                        end else begin
                            state_reg <= ST_ESTART;
                        end
                    end
                end
                ST_HRUN: begin
                    if (eng_done) begin
                        if (h_pos_reg == last_pos) begin
                            rows_done_reg <= 1'b1;
                            state_reg     <= ST_ESTART;
                        end else begin
                            h_pos_reg <= h_pos_reg + PW'(1);
                            hx_reg    <= hx_next;
                            hy_reg    <= hy_next;
                            req_reg   <= '{start: 1'b1, vert: 1'b0, x: hx_next, y: hy_next};
                        end
                    end
                end
                ST_ESTART: begin
                    if (emit_wrap) begin
                        emit_pos_reg <= '0;
                        ex_reg       <= '0;
                        ey_reg       <= '0;
                    end
                    vert_reg  <= 1'b1;
                    req_reg   <= '{start: 1'b1, vert: 1'b1,
                                   x: emit_wrap ? '0 : ex_reg,
                                   y: emit_wrap ? '0 : ey_reg};
                    state_reg <= ST_ERUN;
                end
                ST_ERUN: begin
                    if (eng_done) begin
                        state_reg <= ST_EOUT;
                    end
                end
                ST_EOUT: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_pixel_reg     <= eng_result;
                        m_frame_end_reg <= (emit_pos_reg == last_pos);
                        if (emit_pos_reg == last_pos) begin
                            emit_pos_reg <= '0;
                            load_pos_reg <= '0;
                            ex_reg       <= '0;
                            ey_reg       <= '0;
                        end else begin
                            emit_pos_reg <= emit_pos_reg + PW'(1);
                            ex_reg       <= ex_next;
                            ey_reg       <= ey_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Source pixels as loaded.
    sbb_frame_ram #(.DEPTH(DEPTH), .AW(AW)) u_src_ram (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (load_pos_reg[AW-1:0]),
        .wdata (s_pixel_in),
        .re    (eng_rd_en && !vert_reg),
        .raddr (eng_rd_addr),
        .rdata (src_rdata)
    );

    // Intermediate frame after the horizontal pass.
    sbb_frame_ram #(.DEPTH(DEPTH), .AW(AW)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (h_pos_reg[AW-1:0]),
        .wdata (eng_result),
        .re    (eng_rd_en && vert_reg),
        .raddr (eng_rd_addr),
        .rdata (row_rdata)
    );

    sbb_window #(.AW(AW)) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom),
        .req     (req_reg),
        .rd_en   (eng_rd_en),
        .rd_addr (eng_rd_addr),
        .rd_data (eng_rd_data),
        .done    (eng_done),
        .result  (eng_result)
    );

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_reg;
    assign m_frame_end = m_frame_end_reg;

    a_load_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        load_pos_reg <= total)
        else $error("load position beyond frame");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_pos_reg < total)
        else $error("emit position beyond frame");

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_done |-> (state_reg == ST_HRUN || state_reg == ST_ERUN))
        else $error("window result outside a run");

endmodule
`default_nettype wire

/* tb/tb_separable_box_blur_core.sv */
// Self-checking testbench of separable_box_blur_core: loads frames, emits them blurred and
// checks every emitted pixel against a predictor kept in this file. Depends on sbb_pkg.
`default_nettype none
module tb_separable_box_blur_core;
    import sbb_pkg::*;

    localparam int FRAME_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    // Writes to this index hit no register and must leave the block alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1600;
    localparam int QUIET_CYCLES = 64;

    typedef struct packed {
        logic              command;
        logic [PIXEL_W-1:0] pixel;
    } blur_cmd_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_end;
    } blurred_px_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_command = CMD_LOAD;
    logic [PIXEL_W-1:0]    s_pixel_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PIXEL_W-1:0]    m_pixel_out;
    logic                  m_frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BLUR_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    separable_box_blur_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command), .s_pixel_in(s_pixel_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel_out(m_pixel_out),
        .m_frame_end(m_frame_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Mirror of the block's state, advanced at every accepted item and register write.
    logic [PIXEL_W-1:0]  src_frame [FRAME_WORDS];
    logic [PIXEL_W-1:0]  row_frame [FRAME_WORDS];
    logic [RADIUS_W-1:0] mir_radius = RESET_RADIUS;
    logic [DIM_W-1:0]    mir_width = RESET_WIDTH;
    logic [DIM_W-1:0]    mir_height = RESET_HEIGHT;
    int                  load_pos = 0;
    int                  emit_pos = 0;
    bit                  rows_valid = 0;

    blur_cmd_t   pending_cmds[$];
    blurred_px_t expected_px[$];
    int          errors = 0;
    int          hold_request = 0;   // long receiver hold-off, picked up by the monitor
    bit          no_idle = 0;        // phases where neither side idles

    function automatic int eff_w();
        if (mir_width == 0) return 1;
        return (mir_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(mir_width);
    endfunction

    function automatic int eff_h();
        if (mir_height == 0) return 1;
        return (mir_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(mir_height);
    endfunction

    // Per-lane truncated mean over 2r+1 clamped taps of either frame.
    function automatic logic [PIXEL_W-1:0] lane_mean(bit from_rows, int centre, int hi,
                                                     int base, int stride, int r);
        int sums [LANES];
        int idx;
        logic [PIXEL_W-1:0] px;
        logic [PIXEL_W-1:0] res;
        for (int c = 0; c < LANES; c++) sums[c] = 0;
        for (int k = -r; k <= r; k++) begin
            idx = centre + k;
            if (idx < 0) idx = 0;
            if (idx > hi) idx = hi;
            idx = (base + idx * stride) % FRAME_WORDS;
            px = from_rows ? row_frame[idx] : src_frame[idx];
            for (int c = 0; c < LANES; c++) sums[c] += px[c*LANE_W +: LANE_W];
        end
        res = '0;
        for (int c = 0; c < LANES; c++)
            res[c*LANE_W +: LANE_W] = LANE_W'(sums[c] / (2*r + 1));
        return res;
    endfunction

    task automatic predict_item(input logic cmd, input logic [PIXEL_W-1:0] pix);
        int w;
        int h;
        int total;
        blurred_px_t e;
        w = eff_w();
        h = eff_h();
        total = w * h;
        if (cmd == CMD_LOAD) begin
            if (load_pos < total) begin
                src_frame[load_pos] = pix;
                load_pos++;
                rows_valid = 0;
            end
        end else begin
            if (!rows_valid) begin
                for (int y = 0; y < h; y++)
                    for (int x = 0; x < w; x++)
                        row_frame[y*w + x] = lane_mean(1'b0, x, w - 1, y*w, 1,
                                                       int'(mir_radius));
                rows_valid = 1;
            end
            if (emit_pos >= total) emit_pos = 0;
            e.pixel = lane_mean(1'b1, emit_pos / w, h - 1, emit_pos % w, w, int'(mir_radius));
            e.frame_end = (emit_pos == total - 1);
            expected_px.push_back(e);
            if (e.frame_end) begin
                emit_pos = 0;
                load_pos = 0;
            end else begin
                emit_pos++;
            end
        end
    endtask

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (no_idle || roll < 65) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Driver: offers queued items, holding each until the block accepts it.
    int send_gap = 0;
    always @(posedge aclk) begin
        blur_cmd_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_item(s_command, s_pixel_in);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    it = pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    s_command <= it.command;
                    s_pixel_in <= it.pixel;
                    send_gap = gap_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls at random and compares every accepted pixel with the oldest prediction.
    int stall_left = 0;
    always @(posedge aclk) begin
        blurred_px_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    $display("%0t: unexpected item, pixel_out %h frame_end %b",
                             $time, m_pixel_out, m_frame_end);
                    errors++;
                end else begin
                    e = expected_px.pop_front();
                    if (m_pixel_out !== e.pixel) begin
                        $display("%0t: pixel_out mismatch, expected %h actual %h",
                                 $time, e.pixel, m_pixel_out);
                        errors++;
                    end
                    if (m_frame_end !== e.frame_end) begin
                        $display("%0t: frame_end mismatch, expected %b actual %b",
                                 $time, e.frame_end, m_frame_end);
                        errors++;
                    end
                end
            end
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    // Waits until every item went in and every pixel came out, then lets the block settle.
    // The check runs at the falling edge, where the driver and monitor updates have settled.
    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_valid || expected_px.size() > 0)
            @(negedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // One register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BLUR_RADIUS:  mir_radius = val[RADIUS_W-1:0];
            REG_FRAME_WIDTH:  mir_width = val;
            REG_FRAME_HEIGHT: mir_height = val;
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            load_pos = 0;
            emit_pos = 0;
            rows_valid = 0;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom();
    endfunction

    int planned = 0;

    task automatic queue_item(input logic cmd, input logic [PIXEL_W-1:0] pix);
        blur_cmd_t it;
        it.command = cmd;
        it.pixel = pix;
        pending_cmds.push_back(it);
        planned++;
    endtask

    // A whole frame: configure, load every pixel, then emit in one of several patterns.
    task automatic run_frame(input int r, input int wr, input int hr, input int pattern);
        int total;
        int k;
        write_reg(REG_BLUR_RADIUS, CFG_DATA_W'(r));
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(wr));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(hr));
        total = eff_w() * eff_h();
        for (int i = 0; i < total; i++) queue_item(CMD_LOAD, rand_pixel());
        case (pattern)
            0: for (int i = 0; i < total; i++) queue_item(CMD_EMIT, '0);
            1: begin
                // The frame is emitted twice; the second pass reuses the row results.
                for (int i = 0; i < 2*total; i++) queue_item(CMD_EMIT, $urandom());
            end
            2: begin
                // Loads into a full frame are dropped, even between emits.
                k = $urandom_range(total);
                for (int i = 0; i < k; i++) queue_item(CMD_EMIT, '0);
                for (int i = 0; i < 3; i++) queue_item(CMD_LOAD, rand_pixel());
                for (int i = k; i < total; i++) queue_item(CMD_EMIT, '0);
            end
            default: begin
                // After a full emit, part of the frame is overwritten and emitted again.
                for (int i = 0; i < total; i++) queue_item(CMD_EMIT, '0);
                k = $urandom_range(total, 1);
                for (int i = 0; i < k; i++) queue_item(CMD_LOAD, rand_pixel());
                for (int i = 0; i < total; i++) queue_item(CMD_EMIT, '0);
            end
        endcase
    endtask

    initial begin
        int w;
        int h;
        int k;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames: smallest size through zero dimensions, widest and tallest frames,
        // oversized width, both radius extremes, and a write to the unused index.
        run_frame(0, 0, 0, 1);
        wait_drained();
        run_frame(DEF_MAX_RADIUS, 127, 1, 0);
        wait_drained();
        run_frame(DEF_MAX_RADIUS, 1, DEF_MAX_HEIGHT, 0);
        wait_drained();
        run_frame(3, 3, 4, 2);
        wait_drained();
        write_reg(REG_UNUSED, 7'h7F);
        for (int i = 0; i < 12; i++) queue_item(CMD_EMIT, '0);
        wait_drained();

        // The receiver holds off through the loads and the whole horizontal pass, so finished
        // pixels back up into the block and stall its input.
        run_frame(2, 8, 8, 0);
        hold_request = 4000;
        wait_drained();

        while (planned < ITEM_TARGET) begin
            no_idle = ($urandom_range(5) == 0);
            k = $urandom_range(9);
            if (k == 0) begin
                w = $urandom_range(DEF_MAX_WIDTH, 9);
                h = 1;
            end else begin
                w = $urandom_range(8, 1);
                h = $urandom_range(8, 1);
            end
            run_frame($urandom_range(DEF_MAX_RADIUS), w, h, $urandom_range(3));
            wait_drained();
            if ($urandom_range(7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/sbb_pkg.sv
rtl/sbb_frame_ram.sv
rtl/sbb_div4.sv
rtl/sbb_window.sv
rtl/separable_box_blur_core.sv
tb/tb_separable_box_blur_core.sv
